/* src/gbsa_pkg.sv */
// gbsa_pkg: types, constants and tables for the gradient bandit softmax agent
// used by every module of the block

package gbsa_pkg;

    localparam int PREF_W = 32;
    localparam int PROB_W = 17;
    localparam int VAL_W = 24;
    localparam int CFG_W = 17;
    localparam int EXP_W = 33;
    localparam int EXP_BITS = 21;
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] CFG_ARM_COUNT = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE = 2'd1;
    localparam logic [1:0] CFG_AVG_MODE = 2'd2;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CONST = 2'd1;

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_REWARD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAX,
        ST_EXP_LOAD,
        ST_EXP_BIT,
        ST_EXP_STORE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_AVG_LOAD,
        ST_AVG_RUN,
        ST_AVG_DONE,
        ST_GRAD,
        ST_PREF,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start_choose;
        logic start_reward;
        logic max_step;
        logic exp_load;
        logic exp_bit;
        logic exp_store;
        logic div_load;
        logic div_run;
        logic div_store;
        logic avg_load;
        logic avg_run;
        logic avg_done;
        logic grad;
        logic pref_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic arm_last;
        logic bit_last;
        logic div_last;
        logic avg_last;
    } status_t;

    function automatic logic [31:0] exp_entry(input logic [4:0] b);
        logic [31:0] v;
        begin
            case (b)
                5'd0: v = 32'd4294901760;
                5'd1: v = 32'd4294836226;
                5'd2: v = 32'd4294705160;
                5'd3: v = 32'd4294443040;
                5'd4: v = 32'd4293918848;
                5'd5: v = 32'd4292870656;
                5'd6: v = 32'd4290775039;
                5'd7: v = 32'd4286586875;
                5'd8: v = 32'd4278222805;
                5'd9: v = 32'd4261543595;
                5'd10: v = 32'd4228380000;
                5'd11: v = 32'd4162825044;
                5'd12: v = 32'd4034748382;
                5'd13: v = 32'd3790295335;
                5'd14: v = 32'd3344923893;
                5'd15: v = 32'd2605029347;
                5'd16: v = 32'd1580030169;
                5'd17: v = 32'd581260615;
                5'd18: v = 32'd78665070;
                5'd19: v = 32'd1440801;
                5'd20: v = 32'd483;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* src/gradient_bandit_softmax_agent.sv */
// gradient_bandit_softmax_agent: top level of the softmax gradient bandit
// depends on gbsa_pkg, gbsa_ctrl, gbsa_datapath
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | op, uniform_draw, reward_value
//  out     | out_valid / out_stall| chosen_arm, chosen_probability, average_value
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// choose: a max search over the arms, then per arm the bit-serial exp multiply,
//   then per arm the one-bit-a-step normalizing divider, then the output load
// reward: the serial sample-average divider, the gradient, then the per-arm preference update
// reset clears preferences, average and count and sets the default configuration at once
// one request at a time; a result waiting on out_stall holds off new requests

module gradient_bandit_softmax_agent #(
    parameter int MAX_ARMS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [gbsa_pkg::PROB_W-1:0]       uniform_draw,
    input  logic signed [gbsa_pkg::VAL_W-1:0] reward_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        chosen_arm,
    output logic [gbsa_pkg::PROB_W-1:0]       chosen_probability,
    output logic signed [gbsa_pkg::VAL_W-1:0] average_value,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [gbsa_pkg::CFG_W-1:0]        cfg_data
);
    import gbsa_pkg::*;

    cmd_t cmd;
    status_t status;

    // sequencer
    gbsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    gbsa_datapath #(
        .MAX_ARMS  (MAX_ARMS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .uniform_draw       (uniform_draw),
        .reward_value       (reward_value),
        .chosen_arm         (chosen_arm),
        .chosen_probability (chosen_probability),
        .average_value      (average_value)
    );

endmodule

/* src/gbsa_ctrl.sv */
// gbsa_ctrl: sequencer for choose and reward requests
// depends on gbsa_pkg

module gbsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  gbsa_pkg::status_t  status,
    output gbsa_pkg::cmd_t     cmd
);
    import gbsa_pkg::*;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign accept = in_valid && !in_stall;
    // busy while any state but idle, or result waiting
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (in_op == OP_CHOOSE) ? ST_MAX : ST_AVG_LOAD;
            ST_MAX: if (status.arm_last) state_next = ST_EXP_LOAD;
            ST_EXP_LOAD: state_next = ST_EXP_BIT;
            ST_EXP_BIT: if (status.bit_last) state_next = ST_EXP_STORE;
            ST_EXP_STORE:
                state_next = status.arm_last ? ST_DIV_LOAD : ST_EXP_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_RUN;
            ST_DIV_RUN: if (status.div_last) state_next = ST_DIV_STORE;
            ST_DIV_STORE: state_next = status.arm_last ? ST_OUT : ST_DIV_LOAD;
            ST_AVG_LOAD: state_next = ST_AVG_RUN;
            ST_AVG_RUN: if (status.avg_last) state_next = ST_AVG_DONE;
            ST_AVG_DONE: state_next = ST_GRAD;
            ST_GRAD: state_next = ST_PREF;
            ST_PREF: if (status.arm_last) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.start_choose = accept && (in_op == OP_CHOOSE);
        cmd.start_reward = accept && (in_op == OP_REWARD);
        unique case (state_reg)
            ST_MAX: cmd.max_step = 1'b1;
            ST_EXP_LOAD: cmd.exp_load = 1'b1;
            ST_EXP_BIT: cmd.exp_bit = 1'b1;
            ST_EXP_STORE: cmd.exp_store = 1'b1;
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIV_RUN: cmd.div_run = 1'b1;
            ST_DIV_STORE: cmd.div_store = 1'b1;
            ST_AVG_LOAD: cmd.avg_load = 1'b1;
            ST_AVG_RUN: cmd.avg_run = 1'b1;
            ST_AVG_DONE: cmd.avg_done = 1'b1;
            ST_GRAD: cmd.grad = 1'b1;
            ST_PREF: cmd.pref_step = 1'b1;
            ST_OUT: cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == ST_OUT)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("request accepted while busy");
    a_out_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid_reg)
        else $error("result not raised");
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle");
`endif

endmodule

/* src/gbsa_datapath.sv */
// gbsa_datapath: preferences, policy, exp unit, serial dividers and updates
// depends on gbsa_pkg

module gbsa_datapath #(
    parameter int MAX_ARMS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gbsa_pkg::cmd_t                    cmd,
    output gbsa_pkg::status_t                 status,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [gbsa_pkg::CFG_W-1:0]        cfg_data,
    input  logic [gbsa_pkg::PROB_W-1:0]       uniform_draw,
    input  logic signed [gbsa_pkg::VAL_W-1:0] reward_value,
    output logic [3:0]                        chosen_arm,
    output logic [gbsa_pkg::PROB_W-1:0]       chosen_probability,
    output logic signed [gbsa_pkg::VAL_W-1:0] average_value
);
    import gbsa_pkg::*;

    localparam int IW = $clog2(MAX_ARMS);
    localparam int CW = IW + 1;
    localparam int PW = FRAC_BITS + 1;
    localparam int SUM_W = EXP_W + CW;
    localparam int NUM_W = EXP_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic signed [PREF_W-1:0] pref_reg [MAX_ARMS];
    logic [PW-1:0] pol_reg [MAX_ARMS];
    logic [EXP_W-1:0] e_reg [MAX_ARMS];

    logic [4:0] arm_count_reg;
    logic [16:0] step_size_reg;
    logic [1:0] avg_mode_reg;

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] last_reg;
    logic [IW-1:0] chosen_reg;
    logic found_reg;
    logic signed [PREF_W-1:0] top_reg;
    logic [EXP_W-1:0] acc_reg;
    logic [20:0] d_reg;
    logic [4:0] bit_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PW-1:0] cum_reg;
    logic [PROB_W-1:0] draw_reg;

    // restoring divider for the policy
    logic [NUM_W-1:0] quo_reg;
    logic [SUM_W:0] rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // sample average divider (26 bit magnitude over 33 bit count)
    logic [25:0] aq_reg;
    logic [33:0] ar_reg;
    logic [32:0] aden_reg;
    logic [4:0] acnt_reg;
    logic aneg_reg;
    logic signed [25:0] diff_reg;

    logic signed [VAL_W-1:0] avg_reg;
    logic [31:0] count_reg;
    logic signed [VAL_W-1:0] r_reg;
    logic signed [42:0] g_reg;
    logic [3:0] out_arm_reg;
    logic [PROB_W-1:0] out_prob_reg;

    logic [CW-1:0] n_act;
    logic [16:0] step_eff;
    logic [IW-1:0] last_idx;

    always_comb
    begin
        if (arm_count_reg == 5'd0)
            n_act = CW'(1);
        else if (32'(arm_count_reg) > MAX_ARMS)
            n_act = CW'(MAX_ARMS);
        else
            n_act = CW'(arm_count_reg);
    end
    assign step_eff = (step_size_reg > 17'd65536) ? 17'd65536 : step_size_reg;
    assign last_idx = IW'(n_act - CW'(1));

    assign status.arm_last = (idx_reg == last_idx);
    assign status.bit_last = (bit_reg == 5'(EXP_BITS - 1));
    assign status.div_last = (dcnt_reg == DCNT_W'(NUM_W - 1));
    assign status.avg_last = (acnt_reg == 5'd25);

    // exp multiply, rounded half up
    logic [64:0] mul_w;
    logic [PREF_W:0] dfull;
    logic [PREF_W+16:0] dscaled;
    assign mul_w = 65'(acc_reg) * 65'(exp_entry(bit_reg)) + 65'(64'h8000_0000);
    assign dfull = (PREF_W + 1)'(top_reg) - (PREF_W + 1)'(pref_reg[idx_reg]);
    assign dscaled = {dfull, 16'd0} >> FRAC_BITS;

    // divider step
    logic [SUM_W:0] rem_sh;
    assign rem_sh = {rem_reg[SUM_W-1:0], quo_reg[NUM_W-1]};
    logic [34:0] ar_sh;
    assign ar_sh = 35'({ar_reg[32:0], aq_reg[25]});

    // average and gradient arithmetic
    logic signed [25:0] rd_w;
    logic signed [44:0] sprod_w;
    logic signed [25:0] avg_new;
    logic signed [25:0] aq_s;
    assign rd_w = 26'(r_reg) - 26'(avg_reg);
    assign sprod_w = 45'($signed({1'b0, step_eff})) * 45'(diff_reg);
    assign aq_s = aneg_reg ? -$signed(aq_reg) : $signed(aq_reg);

    always_comb
    begin
        avg_new = 26'(avg_reg);
        if (avg_mode_reg == MODE_SAMPLE)
            avg_new = 26'(avg_reg) + aq_s;
        else if (avg_mode_reg == MODE_CONST)
            avg_new = 26'(avg_reg) + 26'(sprod_w >>> 16);
        if (avg_new > 26'sd8388607)
            avg_new = 26'sd8388607;
        else if (avg_new < -26'sd8388608)
            avg_new = -26'sd8388608;
    end

    logic signed [PW+1:0] ind_w;
    logic signed [PW+44:0] adj_prod;
    logic signed [PREF_W+1:0] pref_sum;
    logic signed [PREF_W-1:0] pref_sat;
    assign ind_w = ((idx_reg == last_reg) ? (PW + 2)'(1 << FRAC_BITS) : '0)
                   - (PW + 2)'(pol_reg[idx_reg]);
    assign adj_prod = (PW + 45)'(g_reg) * (PW + 45)'(ind_w);
    assign pref_sum = (PREF_W + 2)'(pref_reg[idx_reg])
                      + (PREF_W + 2)'(adj_prod >>> FRAC_BITS);
    always_comb
    begin
        if (pref_sum > (PREF_W + 2)'(33'sh0_7FFF_FFFF))
            pref_sat = {1'b0, {(PREF_W - 1){1'b1}}};
        else if (pref_sum < -(PREF_W + 2)'(34'sh0_8000_0000))
            pref_sat = {1'b1, {(PREF_W - 1){1'b0}}};
        else
            pref_sat = PREF_W'(pref_sum);
    end

    logic [PW-1:0] cum_new;
    assign cum_new = cum_reg + PW'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_count_reg <= 5'd16;
            step_size_reg <= 17'd6554;
            avg_mode_reg <= 2'd0;
            for (int i = 0; i < MAX_ARMS; i++)
                pref_reg[i] <= '0;
            avg_reg <= '0;
            count_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ARM_COUNT: arm_count_reg <= cfg_data[4:0];
                    CFG_STEP_SIZE: step_size_reg <= cfg_data;
                    CFG_AVG_MODE: avg_mode_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cmd.div_store && status.arm_last)
                last_reg <= (found_reg || (PW'(draw_reg) <= cum_new))
                            ? (found_reg ? chosen_reg : idx_reg) : last_idx;
            if (cmd.avg_done)
            begin
                avg_reg <= VAL_W'(avg_new);
                if (count_reg != 32'hFFFF_FFFF)
                    count_reg <= count_reg + 32'd1;
            end
            if (cmd.pref_step)
                pref_reg[idx_reg] <= pref_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_choose)
        begin
            idx_reg <= '0;
            top_reg <= pref_reg[0];
            sum_reg <= '0;
            draw_reg <= PROB_W'((33'(uniform_draw) << FRAC_BITS) >> 16);
        end
        if (cmd.start_reward)
        begin
            r_reg <= reward_value;
            idx_reg <= '0;
        end
        if (cmd.max_step)
        begin
            if (pref_reg[idx_reg] > top_reg)
                top_reg <= pref_reg[idx_reg];
            idx_reg <= status.arm_last ? '0 : idx_reg + IW'(1);
        end
        if (cmd.exp_load)
        begin
            acc_reg <= EXP_W'(64'h1_0000_0000);
            // distance of 32.0 or more saturates
            if (dscaled >= (PREF_W + 17)'(1 << 21))
                d_reg <= '1;
            else
                d_reg <= 21'(dscaled);
            bit_reg <= '0;
        end
        if (cmd.exp_bit)
        begin
            if (d_reg[bit_reg])
                acc_reg <= EXP_W'(mul_w >> 32);
            bit_reg <= bit_reg + 5'd1;
        end
        if (cmd.exp_store)
        begin
            // saturated distance maps to zero
            e_reg[idx_reg] <= (d_reg == '1) ? '0 : acc_reg;
            sum_reg <= sum_reg + SUM_W'((d_reg == '1) ? '0 : acc_reg);
            idx_reg <= status.arm_last ? '0 : idx_reg + IW'(1);
            cum_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.div_load)
        begin
            quo_reg <= NUM_W'(e_reg[idx_reg]) << FRAC_BITS;
            rem_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_run)
        begin
            if (rem_sh >= (SUM_W + 1)'(sum_reg))
            begin
                rem_reg <= rem_sh - (SUM_W + 1)'(sum_reg);
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.div_store)
        begin
            pol_reg[idx_reg] <= PW'(quo_reg);
            cum_reg <= cum_new;
            if (!found_reg && (PW'(draw_reg) <= cum_new))
            begin
                found_reg <= 1'b1;
                chosen_reg <= idx_reg;
            end
            idx_reg <= status.arm_last ? '0 : idx_reg + IW'(1);
        end
        if (cmd.avg_load)
        begin
            diff_reg <= rd_w;
            aneg_reg <= rd_w[25];
            aq_reg <= rd_w[25] ? 26'(-rd_w) : 26'(rd_w);
            ar_reg <= '0;
            aden_reg <= 33'(count_reg) + 33'd1;
            acnt_reg <= '0;
        end
        if (cmd.avg_run)
        begin
            if (ar_sh >= 35'(aden_reg))
            begin
                ar_reg <= 34'(ar_sh - 35'(aden_reg));
                aq_reg <= {aq_reg[24:0], 1'b1};
            end
            else
            begin
                ar_reg <= 34'(ar_sh);
                aq_reg <= {aq_reg[24:0], 1'b0};
            end
            acnt_reg <= acnt_reg + 5'd1;
        end
        if (cmd.avg_done)
            diff_reg <= 26'(r_reg) - avg_new;
        if (cmd.grad)
            g_reg <= 43'(sprod_w >>> 16);
        if (cmd.pref_step)
            idx_reg <= status.arm_last ? '0 : idx_reg + IW'(1);
        if (cmd.out_load)
        begin
            out_arm_reg <= 4'(last_reg);
            out_prob_reg <= PROB_W'(pol_reg[last_reg]);
        end
    end

    assign chosen_arm = out_arm_reg;
    assign chosen_probability = out_prob_reg;
    assign average_value = avg_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pref_step |-> (CW'(idx_reg) < n_act))
        else $error("arm index beyond active arms");
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.avg_done |=> (count_reg != 32'd0))
        else $error("reward count did not advance");
    a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (CW'(last_reg) < CW'(MAX_ARMS)))
        else $error("last arm out of range");
`endif

endmodule

/* verif/gradient_bandit_softmax_agent_tb.sv */
// gradient_bandit_softmax_agent_tb: self-checking bench for the softmax gradient bandit
// depends on gbsa_pkg and gradient_bandit_softmax_agent; directed table then random phases

module gradient_bandit_softmax_agent_tb;

    import gbsa_pkg::*;

    localparam int NARMS = 16;
    localparam int RAND_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] MODE_HOLD = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint PROB_ONE = 65536;
    localparam longint AVG_MAX = 8388607;
    localparam longint AVG_MIN = -8388608;
    localparam longint PREF_MAX = 64'sd2147483647;
    localparam longint PREF_MIN = -64'sd2147483648;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [3:0]              arm;
        logic [PROB_W-1:0]       prob;
        logic signed [VAL_W-1:0] avg;
    } result_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [1:0]              idx;
        logic [CFG_W-1:0]        data;
        logic                    opc;
        logic [PROB_W-1:0]       draw;
        logic signed [VAL_W-1:0] rew;
        logic                    typed;
        result_t                 want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic op;
    logic [PROB_W-1:0] uniform_draw;
    logic signed [VAL_W-1:0] reward_value;
    logic out_valid;
    logic out_stall;
    logic [3:0] chosen_arm;
    logic [PROB_W-1:0] chosen_probability;
    logic signed [VAL_W-1:0] average_value;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gradient_bandit_softmax_agent i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .uniform_draw(uniform_draw),
        .reward_value(reward_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .chosen_arm(chosen_arm),
        .chosen_probability(chosen_probability),
        .average_value(average_value),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // exp(-2^(b-16)) in Q0.32, one entry per bit of the distance
    logic [63:0] exp_rom [0:20] = '{
        64'd4294901760, 64'd4294836226, 64'd4294705160, 64'd4294443040, 64'd4293918848,
        64'd4292870656, 64'd4290775039, 64'd4286586875, 64'd4278222805, 64'd4261543595,
        64'd4228380000, 64'd4162825044, 64'd4034748382, 64'd3790295335, 64'd3344923893,
        64'd2605029347, 64'd1580030169, 64'd581260615, 64'd78665070, 64'd1440801,
        64'd483
    };

    // agent state mirrored by the bench
    int prefs [NARMS];
    logic [PROB_W-1:0] policy [NARMS];
    logic [PROB_W-1:0] cumul [NARMS];
    longint avg_q;
    logic [31:0] rcount;
    int last_sel;
    int written_hi;
    logic [4:0] cfg_arms;
    logic [16:0] cfg_step;
    logic [1:0] cfg_mode;

    result_t pending_results [$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent;
    int chooses_sent;
    int rewards_sent;
    int cycles = 0;

    // clock, and a cycle counter that ends a hung run
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("gradient_bandit_softmax_agent_tb: errors");
            $finish;
        end
    end

    function automatic int active_arms();
        if (cfg_arms < 1)
            return 1;
        if (cfg_arms > NARMS)
            return NARMS;
        return int'(cfg_arms);
    endfunction

    // expected result of one accepted request, advancing the mirrored state
    task automatic predict_request(input logic opc, input logic [PROB_W-1:0] draw,
                                   input logic signed [VAL_W-1:0] rew, output result_t res);
        int n;
        longint step;
        longint top;
        longint d;
        longint rr;
        longint a;
        longint g;
        longint ind;
        longint adj;
        longint np;
        logic [63:0] e [NARMS];
        logic [63:0] acc;
        logic [95:0] prod;
        logic [63:0] sum;
        logic [63:0] run;
        bit found;
        begin
            n = active_arms();
            step = (cfg_step > 17'd65536) ? 65536 : longint'(cfg_step);
            if (opc == OP_CHOOSE)
            begin
                top = prefs[0];
                for (int i = 1; i < n; i++)
                    if (prefs[i] > top)
                        top = prefs[i];
                sum = 0;
                for (int i = 0; i < n; i++)
                begin
                    d = top - longint'(prefs[i]);
                    acc = 64'd1 << 32;
                    if (d >= (longint'(1) << 21))
                        acc = 0;
                    else
                        for (int b = 0; b < 21; b++)
                            if (d[b])
                            begin
                                prod = acc * exp_rom[b];
                                prod = (prod + (96'd1 << 31)) >> 32;
                                acc = prod[63:0];
                            end
                    e[i] = acc;
                    sum += acc;
                end
                run = 0;
                for (int i = 0; i < n; i++)
                begin
                    policy[i] = PROB_W'((e[i] << 16) / sum);
                    run += policy[i];
                    cumul[i] = PROB_W'(run);
                end
                // no arm reaching the draw falls back to the last active arm
                last_sel = n - 1;
                found = 1'b0;
                for (int i = 0; i < n; i++)
                    if (!found && draw <= cumul[i])
                    begin
                        last_sel = i;
                        found = 1'b1;
                    end
                if (n > written_hi)
                    written_hi = n;
            end
            else
            begin
                rr = longint'(rew);
                a = avg_q;
                if (cfg_mode == MODE_SAMPLE)
                    a += (rr - a) / ($signed({32'd0, rcount}) + 1);
                else if (cfg_mode == MODE_CONST)
                    a += (step * (rr - a)) >>> 16;
                a = (a > AVG_MAX) ? AVG_MAX : ((a < AVG_MIN) ? AVG_MIN : a);
                avg_q = a;
                if (rcount != 32'hFFFF_FFFF)
                    rcount++;
                g = (step * (rr - a)) >>> 16;
                for (int i = 0; i < n; i++)
                begin
                    ind = (i == last_sel) ? PROB_ONE : 0;
                    adj = (g * (ind - longint'(policy[i]))) >>> 16;
                    np = longint'(prefs[i]) + adj;
                    np = (np > PREF_MAX) ? PREF_MAX : ((np < PREF_MIN) ? PREF_MIN : np);
                    prefs[i] = int'(np);
                end
            end
            res.arm = 4'(last_sel);
            res.prob = policy[last_sel];
            res.avg = VAL_W'(avg_q);
        end
    endtask

    // drive one request, wait for its handshake, then queue what it should return
    task automatic send_request(input logic opc, input logic [PROB_W-1:0] draw,
                                input logic signed [VAL_W-1:0] rew, input bit typed,
                                input result_t want);
        result_t res;
        begin
            @(negedge clk);
            in_valid <= 1'b1;
            op <= opc;
            uniform_draw <= draw;
            reward_value <= rew;
            do
                @(posedge clk);
            while (in_stall);
            predict_request(opc, draw, rew, res);
            pending_results.push_back(typed ? want : res);
            items_sent++;
            if (opc == OP_CHOOSE)
                chooses_sent++;
            else
                rewards_sent++;
        end
    endtask

    task automatic idle_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // registers move only with the block idle and every result back
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        begin
            idle_input(1);
            wait (pending_results.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(negedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_ARM_COUNT)
                cfg_arms = data[4:0];
            else if (idx == CFG_STEP_SIZE)
                cfg_step = data;
            else if (idx == CFG_AVG_MODE)
                cfg_mode = data[1:0];
        end
    endtask

    function automatic row_t item_row(input logic opc, input logic [PROB_W-1:0] draw,
                                      input logic signed [VAL_W-1:0] rew);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.opc = opc;
        r.draw = draw;
        r.rew = rew;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic row_t typed_row(input row_t r, input logic [3:0] arm,
                                       input logic [PROB_W-1:0] prob,
                                       input logic signed [VAL_W-1:0] avg);
        row_t t;
        t = r;
        t.typed = 1'b1;
        t.want.arm = arm;
        t.want.prob = prob;
        t.want.avg = avg;
        return t;
    endfunction

    // result checker: compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result arm=%0d prob=%0d avg=%0d", chosen_arm,
                             chosen_probability, average_value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (chosen_arm !== want.arm || chosen_probability !== want.prob ||
                    average_value !== want.avg)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected arm=%0d prob=%0d avg=%0d,",
                                  " got arm=%0d prob=%0d avg=%0d"},
                                 results_seen, want.arm, want.prob, want.avg, chosen_arm,
                                 chosen_probability, average_value);
                end
            end
        end
    end

    // receiver: free-running stall pattern, plus one long hold-off so the input backs up
    initial
    begin
        int seg;
        int pct;
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            if (!held && results_seen >= 150)
            begin
                held = 1'b1;
                repeat (HOLDOFF_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            seg = $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 25;
                2: pct = 60;
                default: pct = 90;
            endcase
            repeat (seg)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // stimulus
    initial
    begin
        row_t dir_rows [$];
        row_t r;
        int burst_left;
        int phase_len;
        int n_now;
        int sel;
        logic opc;
        logic [PROB_W-1:0] draw;
        logic signed [VAL_W-1:0] rew;
        logic [CFG_W-1:0] stepv;
        logic [4:0] armsv;

        items_sent = 0;
        chooses_sent = 0;
        rewards_sent = 0;
        in_valid = 1'b0;
        op = OP_CHOOSE;
        uniform_draw = '0;
        reward_value = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ARM_COUNT;
        cfg_data = '0;
        foreach (prefs[i])
        begin
            prefs[i] = 0;
            policy[i] = '0;
            cumul[i] = '0;
        end
        avg_q = 0;
        rcount = '0;
        last_sel = 0;
        written_hi = 0;
        cfg_arms = 5'd16;
        cfg_step = 17'd6554;
        cfg_mode = MODE_SAMPLE;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: flat policy of 16 arms gives 4096 each after reset
        dir_rows.push_back(typed_row(item_row(OP_CHOOSE, 17'd0, '0), 4'd0, 17'd4096, '0));
        dir_rows.push_back(typed_row(item_row(OP_CHOOSE, 17'd65536, '0), 4'd15, 17'd4096,
                                     '0));
        // first sample average takes the reward whole; the next one halves the gap
        dir_rows.push_back(typed_row(item_row(OP_REWARD, '0, 24'sh7FFFFF), 4'd15, 17'd4096,
                                     24'sh7FFFFF));
        dir_rows.push_back(typed_row(item_row(OP_REWARD, '0, -24'sh800000), 4'd15,
                                     17'd4096, '0));
        dir_rows.push_back(item_row(OP_CHOOSE, 17'd32768, '0));
        dir_rows.push_back(item_row(OP_REWARD, '0, 24'sd0));
        // arm count zero acts as one arm
        dir_rows.push_back(cfg_row(CFG_ARM_COUNT, 17'd0));
        dir_rows.push_back(item_row(OP_CHOOSE, 17'd65536, '0));
        dir_rows.push_back(item_row(OP_REWARD, '0, 24'sd70000));
        // arm count above range acts as all arms
        dir_rows.push_back(cfg_row(CFG_ARM_COUNT, 17'd31));
        dir_rows.push_back(item_row(OP_CHOOSE, 17'd1, '0));
        // step above one, constant-step average
        dir_rows.push_back(cfg_row(CFG_STEP_SIZE, 17'h1FFFF));
        dir_rows.push_back(cfg_row(CFG_AVG_MODE, {15'd0, MODE_CONST}));
        dir_rows.push_back(item_row(OP_REWARD, '0, 24'sh7FFFFF));
        dir_rows.push_back(item_row(OP_REWARD, '0, -24'sh800000));
        // spare mode code holds the average
        dir_rows.push_back(cfg_row(CFG_AVG_MODE, {15'd0, MODE_SPARE}));
        dir_rows.push_back(item_row(OP_REWARD, '0, 24'sd12345));
        dir_rows.push_back(cfg_row(CFG_STEP_SIZE, 17'd0));
        dir_rows.push_back(item_row(OP_REWARD, '0, -24'sd777));
        dir_rows.push_back(cfg_row(CFG_AVG_MODE, {15'd0, MODE_HOLD}));
        // draw past one: nothing reaches it, last arm wins
        dir_rows.push_back(item_row(OP_CHOOSE, 17'h1FFFF, '0));
        dir_rows.push_back(cfg_row(CFG_ARM_COUNT, 17'd8));
        dir_rows.push_back(item_row(OP_CHOOSE, 17'd65536, '0));
        // shrink below the last chosen arm, then reward it
        dir_rows.push_back(cfg_row(CFG_ARM_COUNT, 17'd2));
        dir_rows.push_back(item_row(OP_REWARD, '0, 24'sd300000));
        dir_rows.push_back(cfg_row(CFG_ARM_COUNT, 17'd16));
        dir_rows.push_back(cfg_row(CFG_STEP_SIZE, 17'd6554));
        dir_rows.push_back(cfg_row(CFG_AVG_MODE, {15'd0, MODE_SAMPLE}));
        dir_rows.push_back(item_row(OP_CHOOSE, 17'd0, '0));

        foreach (dir_rows[k])
        begin
            r = dir_rows[k];
            if (r.kind == ROW_CFG)
                write_reg(r.idx, r.data);
            else
                send_request(r.opc, r.draw, r.rew, r.typed, r.want);
        end

        // random phases: fresh settings, then mostly choose/reward pairs
        burst_left = 0;
        while (items_sent < RAND_ITEMS + dir_rows.size())
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                armsv = 5'd0;
            else if (sel == 1)
                armsv = 5'($urandom_range(17, 31));
            else if (sel <= 3)
                armsv = 5'd16;
            else if (sel <= 5)
                armsv = 5'($urandom_range(5, 15));
            else
                armsv = 5'($urandom_range(1, 4));
            write_reg(CFG_ARM_COUNT, {12'd0, armsv});
            sel = $urandom_range(0, 9);
            if (sel == 0)
                stepv = 17'd0;
            else if (sel == 1)
                stepv = 17'd65536;
            else if (sel == 2)
                stepv = 17'($urandom_range(65537, 131071));
            else
                stepv = 17'($urandom_range(0, 65536));
            write_reg(CFG_STEP_SIZE, stepv);
            write_reg(CFG_AVG_MODE, 17'($urandom_range(0, 3)));

            n_now = active_arms();
            phase_len = $urandom_range(10, 40);
            opc = OP_REWARD;
            for (int j = 0; j < phase_len; j++)
            begin
                // well-formed pairs most of the time, random ops otherwise
                if ($urandom_range(0, 9) < 8)
                    opc = (opc == OP_CHOOSE) ? OP_REWARD : OP_CHOOSE;
                else
                    opc = 1'($urandom_range(0, 1));
                if (j == 0 || n_now > written_hi)
                    opc = OP_CHOOSE;
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    draw = 17'd0;
                else if (sel == 1)
                    draw = 17'd65536;
                else if (sel <= 3)
                    draw = 17'($urandom_range(65537, 131071));
                else
                    draw = 17'($urandom_range(0, 65536));
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    rew = 24'sh7FFFFF;
                else if (sel == 1)
                    rew = -24'sh800000;
                else if (sel <= 4)
                    rew = 24'($urandom);
                else
                    rew = 24'($signed($urandom_range(0, 524288)) - 262144);
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 2) != 0)
                        idle_input($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                send_request(opc, draw, rew, 1'b0, '0);
            end
        end

        idle_input(1);
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d choose, %0d reward)",
                 items_sent, chooses_sent, rewards_sent);
        $display("over random arm counts, steps and averaging modes");
        $display("%0d results checked, %0d mismatches, %0d cycles", results_seen, mismatches,
                 cycles);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("gradient_bandit_softmax_agent_tb: clean");
        else
            $display("gradient_bandit_softmax_agent_tb: errors");
        $finish;
    end

endmodule

/* gradient_bandit_softmax_agent.f */
src/gbsa_pkg.sv
src/gbsa_ctrl.sv
src/gbsa_datapath.sv
src/gradient_bandit_softmax_agent.sv
verif/gradient_bandit_softmax_agent_tb.sv
